// ===== rtl/core/hpvt_pkg.sv =====
package hpvt_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int CHUNK_W        = 16;
   localparam int CHUNK_IDX_W    = 2;
   localparam int FIELD_W        = 32;
   localparam int FRAC_W         = 16;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_POINT  = 2'd1;
   localparam logic [1:0] ACT_VECTOR = 2'd2;

   typedef struct packed {
      logic [1:0]                 action;
      logic [3:0]                 entry_index;
      logic signed [FIELD_W-1:0]  entry_value;
      logic signed [FIELD_W-1:0]  in_x;
      logic signed [FIELD_W-1:0]  in_y;
      logic signed [FIELD_W-1:0]  in_z;
   } hpvt_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0]  out_x;
      logic signed [FIELD_W-1:0]  out_y;
      logic signed [FIELD_W-1:0]  out_z;
      logic                       zero_divisor;
      logic                       saturated;
   } hpvt_rsp_type;

   typedef struct packed {
      logic                   load;
      logic                   mul;
      logic [CHUNK_IDX_W-1:0] chunk;
   } hpvt_mac_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DRAIN,
      ST_EVAL,
      ST_DIV,
      ST_PUT
   } hpvt_state_type;

   function automatic int chunk_count(int dw);
      return (dw + CHUNK_W - 1) / CHUNK_W;
   endfunction

endpackage

// ===== rtl/core/homogeneous_point_vector_transform_top.sv =====
// homogeneous 4x4 transform, Q16.16
// req channel (req_valid / req_stall / req_item): one item per handshake.
//   action write: entry_index / entry_value go into the matrix, no result.
//   action point: (x,y,z,1) times the full matrix, x,y,z divided by w.
//   action vector: (x,y,z,0) times the upper 3x3, no translation, no divide.
//   action code 3 is dropped without a result.
// rsp channel (rsp_valid / rsp_stall / rsp_item): one item per point or vector.
// timing:
//   write: next item taken in the following cycle.
//   point: w==0 is cut short after the w row.
//   every product goes through one 16-bit-chunk multiplier, every quotient
//   through one bit-serial divider; one item is worked on at a time.
// req_stall is high while an item is in work. a finished item sits in the
// output register; the next item is taken meanwhile and only its own result
// waits for the register to drain when rsp_stall is held.
// reset (synchronous): matrix back to identity, no result pending, idle.
module homogeneous_point_vector_transform_top import hpvt_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  hpvt_req_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output hpvt_rsp_type rsp_item
);

   localparam int AW  = 2 * DATA_WIDTH + 2;
   localparam int MW  = 2 * DATA_WIDTH + 1;
   localparam int OW  = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
   localparam int NCH = chunk_count(DATA_WIDTH);
   localparam int XW  = 2 * FIELD_W;

   localparam logic [DATA_WIDTH-1:0] ONE_VAL =
      (DATA_WIDTH >= FRAC_W + 2) ? DATA_WIDTH'(65536) : {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [OW-1:0] MAXP = {1'b0, {(OW-1){1'b1}}};
   localparam logic [OW-1:0] MINN = {1'b1, {(OW-1){1'b0}}};

   hpvt_state_type                state_ff, state_in;
   logic [1:0]                    row_ff, row_in;
   logic [1:0]                    term_ff, term_in;
   logic [CHUNK_IDX_W-1:0]        chunk_ff, chunk_in;
   logic                          point_ff, point_in;
   logic                          neg_ff, neg_in;
   logic                          zdiv_ff, zdiv_in;
   logic                          sat_ff, sat_in;
   logic signed [AW-1:0]          w_ff, w_in;
   logic signed [DATA_WIDTH-1:0]  crd_ff [3];
   logic signed [DATA_WIDTH-1:0]  crd_in [3];
   logic [OW-1:0]                 res_ff [3];
   logic [OW-1:0]                 res_in [3];
   logic signed [DATA_WIDTH-1:0]  mat_ff [16];
   hpvt_rsp_type                  rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          mat_we;

   logic [XW-1:0]                 val_x64, x_x64, y_x64, z_x64;
   logic [3:0]                    rd_addr;
   logic signed [DATA_WIDTH-1:0]  mat_rd;
   hpvt_mac_ctl_type              mac_ctl;
   logic signed [AW-1:0]          mac_init;
   logic signed [AW-1:0]          mac_acc;
   logic signed [AW-1:0]          acc_abs, w_abs;
   logic signed [AW-1:0]          vfull;
   logic [OW-1:0]                 vec_val;
   logic                          vec_sat;
   logic [OW-1:0]                 pt_val;
   logic                          pt_sat;
   logic                          div_start;
   logic [OW-1:0]                 div_quot;
   logic                          div_over;
   logic                          div_done;

   // fields are taken as their low DATA_WIDTH bits of the sign-extended value
   assign val_x64 = XW'(req_item.entry_value);
   assign x_x64   = XW'(req_item.in_x);
   assign y_x64   = XW'(req_item.in_y);
   assign z_x64   = XW'(req_item.in_z);

   assign rd_addr  = {row_ff, (state_ff == ST_LOAD) ? 2'd3 : term_ff};
   assign mat_rd   = mat_ff[rd_addr];
   assign mac_init = point_ff ? (AW'(mat_rd) <<< FRAC_W) : '0;

   hpvt_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .init  (mac_init),
      .op_a  (mat_rd),
      .op_b  (crd_ff[term_ff]),
      .acc   (mac_acc)
   );

   assign acc_abs = mac_acc[AW-1] ? -mac_acc : mac_acc;
   assign w_abs   = w_ff[AW-1] ? -w_ff : w_ff;

   hpvt_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag (acc_abs[MW-1:0]),
      .den_mag (w_abs[MW-1:0]),
      .quot    (div_quot),
      .over    (div_over),
      .done    (div_done)
   );

   // vector rounding is a floor, then clip to the output range
   assign vfull = mac_acc >>> FRAC_W;
   always_comb begin
      vec_sat = 1'b0;
      vec_val = vfull[OW-1:0];
      if (!((&vfull[AW-1:OW-1]) || !(|vfull[AW-1:OW-1]))) begin
         vec_sat = 1'b1;
         vec_val = vfull[AW-1] ? MINN : MAXP;
      end
   end

   always_comb begin
      pt_sat = 1'b0;
      pt_val = div_quot;
      if (div_over) begin
         pt_sat = 1'b1;
         pt_val = neg_ff ? MINN : MAXP;
      end else if (neg_ff) begin
         if (div_quot > MINN) begin
            pt_sat = 1'b1;
            pt_val = MINN;
         end else begin
            pt_val = -div_quot;
         end
      end else if (div_quot > MAXP) begin
         pt_sat = 1'b1;
         pt_val = MAXP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      term_in      = term_ff;
      chunk_in     = chunk_ff;
      point_in     = point_ff;
      neg_in       = neg_ff;
      zdiv_in      = zdiv_ff;
      sat_in       = sat_ff;
      w_in         = w_ff;
      crd_in       = crd_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mat_we       = 1'b0;
      mac_ctl      = '0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.action == ACT_WRITE) begin
                  mat_we = 1'b1;
               end else if (req_item.action inside {ACT_POINT, ACT_VECTOR}) begin
                  point_in  = (req_item.action == ACT_POINT);
                  row_in    = (req_item.action == ACT_POINT) ? 2'd3 : 2'd0;
                  term_in   = '0;
                  chunk_in  = '0;
                  zdiv_in   = 1'b0;
                  sat_in    = 1'b0;
                  crd_in[0] = x_x64[DATA_WIDTH-1:0];
                  crd_in[1] = y_x64[DATA_WIDTH-1:0];
                  crd_in[2] = z_x64[DATA_WIDTH-1:0];
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            mac_ctl.load = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            mac_ctl.mul   = 1'b1;
            mac_ctl.chunk = chunk_ff;
            if (chunk_ff == CHUNK_IDX_W'(NCH - 1)) begin
               chunk_in = '0;
               if (term_ff == 2'd2) begin
                  term_in  = '0;
                  state_in = ST_DRAIN;
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end else begin
               chunk_in = chunk_ff + CHUNK_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (row_ff == 2'd3) begin
               w_in = mac_acc;
               if (mac_acc == '0) begin
                  res_in   = '{default: '0};
                  zdiv_in  = 1'b1;
                  state_in = ST_PUT;
               end else begin
                  row_in   = 2'd0;
                  state_in = ST_LOAD;
               end
            end else if (point_ff) begin
               div_start = 1'b1;
               neg_in    = mac_acc[AW-1] ^ w_ff[AW-1];
               state_in  = ST_DIV;
            end else begin
               res_in[row_ff] = vec_val;
               sat_in         = sat_ff | vec_sat;
               if (row_ff == 2'd2) begin
                  state_in = ST_PUT;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in[row_ff] = pt_val;
               sat_in         = sat_ff | pt_sat;
               if (row_ff == 2'd2) begin
                  state_in = ST_PUT;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.out_x        = FIELD_W'($signed(res_ff[0]));
               rsp_in.out_y        = FIELD_W'($signed(res_ff[1]));
               rsp_in.out_z        = FIELD_W'($signed(res_ff[2]));
               rsp_in.zero_divisor = zdiv_ff;
               rsp_in.saturated    = sat_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? ONE_VAL : '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (mat_we) begin
            mat_ff[req_item.entry_index] <= val_x64[DATA_WIDTH-1:0];
         end
      end
      row_ff   <= row_in;
      term_ff  <= term_in;
      chunk_ff <= chunk_in;
      point_ff <= point_in;
      neg_ff   <= neg_in;
      zdiv_ff  <= zdiv_in;
      sat_ff   <= sat_in;
      w_ff     <= w_in;
      crd_ff   <= crd_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.zero_divisor && rsp_ff.saturated))
      else $error("zero divisor and saturation flagged together");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_divisor |->
         rsp_ff.out_x == '0 && rsp_ff.out_y == '0 && rsp_ff.out_z == '0)
      else $error("zero divisor item carries nonzero coordinates");

endmodule

// ===== rtl/core/hpvt_mac.sv =====
module hpvt_mac import hpvt_pkg::*; #(
   parameter int  DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int AW         = 2 * DATA_WIDTH + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hpvt_mac_ctl_type             ctl,
   input  logic signed [AW-1:0]         init,
   input  logic signed [DATA_WIDTH-1:0] op_a,
   input  logic signed [DATA_WIDTH-1:0] op_b,
   output logic signed [AW-1:0]         acc
);

   localparam int NCH = chunk_count(DATA_WIDTH);
   localparam int BW  = NCH * CHUNK_W;
   localparam int PW  = DATA_WIDTH + CHUNK_W + 1;

   logic signed [BW-1:0]      b_ext;
   logic [CHUNK_W-1:0]        b_part;
   logic signed [CHUNK_W:0]   b_sel;
   logic signed [PW-1:0]      prod_in;
   logic signed [PW-1:0]      prod_ff;
   logic [CHUNK_IDX_W-1:0]    shift_ff;
   logic                      pv_ff;
   logic signed [AW-1:0]      term;
   logic signed [AW-1:0]      acc_in;
   logic signed [AW-1:0]      acc_ff;

   assign b_ext   = BW'(op_b);
   assign b_part  = b_ext[ctl.chunk * CHUNK_W +: CHUNK_W];
   assign b_sel   = (ctl.chunk == CHUNK_IDX_W'(NCH - 1)) ? {b_part[CHUNK_W-1], b_part}
                                                         : {1'b0, b_part};
   assign prod_in = op_a * b_sel;

   assign term = AW'(prod_ff) <<< (CHUNK_W * shift_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = init;
      end else if (pv_ff) begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctl.mul;
      end
      prod_ff  <= prod_in;
      shift_ff <= ctl.chunk;
      acc_ff   <= acc_in;
   end

   assign acc = acc_ff;

   // a fresh row must not start while a partial product is still in flight
   assert property (@(posedge clock) disable iff (reset) ctl.load |-> !pv_ff)
      else $error("accumulator load collides with pending product");

endmodule

// ===== rtl/core/hpvt_div.sv =====
module hpvt_div import hpvt_pkg::*; #(
   parameter int  DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int MW         = 2 * DATA_WIDTH + 1,
   localparam int OW         = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] num_mag,
   input  logic [MW-1:0] den_mag,
   output logic [OW-1:0] quot,
   output logic          over,
   output logic          done
);

   localparam int NW   = MW + FRAC_W;
   localparam int HW   = NW - OW;
   localparam int CNTW = $clog2(OW + 1);

   logic [NW-1:0]   dividend;
   logic [HW-1:0]   hi;
   logic [MW-1:0]   hi_ext;
   logic            over_start;
   logic [MW:0]     trial;
   logic [MW:0]     diff;
   logic            ge;

   logic [MW-1:0]   rem_ff;
   logic [OW-1:0]   sh_ff;
   logic [MW-1:0]   den_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            over_ff;
   logic            done_ff;

   assign dividend   = {num_mag, {FRAC_W{1'b0}}};
   assign hi         = dividend[NW-1:OW];
   assign hi_ext     = MW'(hi);
   assign over_start = (hi_ext >= den_mag);

   assign trial = {rem_ff, sh_ff[OW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (over_start) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && (cnt_ff == CNTW'(1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         den_ff  <= den_mag;
         over_ff <= over_start;
         rem_ff  <= hi_ext;
         sh_ff   <= dividend[OW-1:0];
         cnt_ff  <= CNTW'(OW);
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[MW-1:0] : trial[MW-1:0];
         sh_ff  <= {sh_ff[OW-2:0], ge};
         cnt_ff <= cnt_ff - CNTW'(1);
      end
   end

   assign quot = sh_ff;
   assign over = over_ff;
   assign done = done_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule
